/* rtl/core/tga_rle_pkg.sv */
// shared types and constants for the run-length coded tga pixel decoder
// used by tga_rle_cfg, tga_rle_core and tga_rle_pixel_decoder; no dependencies
package tga_rle_pkg;

	localparam int unsigned DIM_W       = 16;
	localparam int unsigned COUNT_W     = 2 * DIM_W;
	localparam int unsigned CFG_INDEX_W = 2;
	localparam int unsigned CFG_DATA_W  = DIM_W;

	localparam logic [7:0] RAW_BIAS    = 8'd1;
	localparam logic [7:0] REPEAT_BIAS = 8'd127;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_IMAGE_WIDTH  = 2'd0,
		REG_IMAGE_HEIGHT = 2'd1,
		REG_HAS_ALPHA    = 2'd2
	} reg_index_t;

	typedef enum logic [1:0] {
		BYTE_BLUE  = 2'd0,
		BYTE_GREEN = 2'd1,
		BYTE_RED   = 2'd2,
		BYTE_ALPHA = 2'd3
	} byte_pos_t;

	typedef enum logic {
		STATUS_OK       = 1'b0,
		STATUS_OVERFLOW = 1'b1
	} status_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       first;
	} in_item_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] run_length;
		logic       image_done;
		logic       status;
	} out_item_t;

	typedef struct packed {
		logic [COUNT_W-1:0] total;
		logic               has_alpha;
	} cfg_t;

endpackage

/* rtl/core/tga_rle_pixel_decoder.sv */
// top level of the run-length coded tga pixel decoder: input and result registers
// depends on tga_rle_pkg, tga_rle_cfg and tga_rle_core
//
// usage:
//   pkt_valid / pkt_stall / pkt carry the packet byte stream, one byte per item;
//   pkt.first marks the first byte of an image and restarts all counters.
//   pix_valid / pix_stall / pix carry decoded pixels as rgb(a) with a run length;
//   a repeat packet gives one item, a raw packet one item per pixel.
//   cfg_we / cfg_index / cfg_data write image width, height and the alpha flag;
//   write them only while no byte is in flight.
// timing:
//   one byte is taken every cycle while pkt_stall is low; each byte is held in
//   the input register, and its pixel, if any, is then written into the result
//   register, from which it is offered on pix / pix_valid.
//   the rate is set by the single decode pass between the two registers.
// stall and reset:
//   while pix_stall holds a pending pixel, bytes that give no pixel still move
//   on; a byte that would give a pixel waits, and pkt_stall rises behind it.
//   reset sets width and height to 1, clears the alpha flag and all counters,
//   and empties both registers.
module tga_rle_pixel_decoder (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                pkt_valid,
	output logic                                pkt_stall,
	input  tga_rle_pkg::in_item_t               pkt,
	output logic                                pix_valid,
	input  logic                                pix_stall,
	output tga_rle_pkg::out_item_t              pix,
	input  logic                                cfg_we,
	input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data
);

	tga_rle_pkg::cfg_t      cfg;
	tga_rle_pkg::in_item_t  item_s1;
	logic                   valid_s1;
	tga_rle_pkg::out_item_t res_q;
	logic                   res_valid_q;
	tga_rle_pkg::out_item_t result;
	logic                   emit;
	logic                   out_free;
	logic                   advance;
	logic                   pkt_take;

	tga_rle_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tga_rle_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg),
		.emit    (emit),
		.result  (result)
	);

	assign out_free  = !res_valid_q || !pix_stall;
	assign advance   = valid_s1 && (!emit || out_free);
	assign pkt_stall = valid_s1 && !advance;
	assign pkt_take  = pkt_valid && !pkt_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (pkt_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pkt_take)
			item_s1 <= pkt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance && emit) begin
			res_valid_q <= 1'b1;
		end else if (!pix_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit)
			res_q <= result;
	end

	assign pix_valid = res_valid_q;
	assign pix       = res_q;

`ifndef SYNTHESIS
	a_overflow_blank: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix.status) |-> (pix.run_length == 8'd0 && !pix.image_done
			&& pix.red == 8'd0 && pix.alpha == 8'd0))
		else $error("overflow item carries pixel data");
	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && !pix.status) |-> pix.run_length != 8'd0)
		else $error("pixel item with zero run length");
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		pkt_stall |-> (valid_s1 && emit && res_valid_q && pix_stall))
		else $error("byte stalled without a blocked pixel");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && pix_stall) |=> $stable(res_q))
		else $error("pending pixel overwritten");
`endif

endmodule

/* rtl/core/tga_rle_cfg.sv */
// configuration registers: image size, pixel count and alpha flag
// depends on tga_rle_pkg
module tga_rle_cfg (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [tga_rle_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tga_rle_pkg::CFG_DATA_W-1:0]  cfg_data,
	output tga_rle_pkg::cfg_t                   cfg
);

	logic [tga_rle_pkg::DIM_W-1:0]   width_q;
	logic [tga_rle_pkg::DIM_W-1:0]   height_q;
	logic                            alpha_q;
	logic [tga_rle_pkg::COUNT_W-1:0] total_q;

	// pixel count is formed at write time so it is valid on the very next edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= tga_rle_pkg::DIM_W'(1);
			height_q <= tga_rle_pkg::DIM_W'(1);
			alpha_q  <= 1'b0;
			total_q  <= tga_rle_pkg::COUNT_W'(1);
		end else if (cfg_we) begin
			unique case (tga_rle_pkg::reg_index_t'(cfg_index))
				tga_rle_pkg::REG_IMAGE_WIDTH: begin
					width_q <= cfg_data[tga_rle_pkg::DIM_W-1:0];
					total_q <= tga_rle_pkg::COUNT_W'(cfg_data[tga_rle_pkg::DIM_W-1:0])
						* tga_rle_pkg::COUNT_W'(height_q);
				end
				tga_rle_pkg::REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data[tga_rle_pkg::DIM_W-1:0];
					total_q  <= tga_rle_pkg::COUNT_W'(width_q)
						* tga_rle_pkg::COUNT_W'(cfg_data[tga_rle_pkg::DIM_W-1:0]);
				end
				tga_rle_pkg::REG_HAS_ALPHA: begin
					alpha_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.total     = total_q;
	assign cfg.has_alpha = alpha_q;

`ifndef SYNTHESIS
	a_total_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$past(arst_n) |-> total_q == tga_rle_pkg::COUNT_W'(width_q)
			* tga_rle_pkg::COUNT_W'(height_q))
		else $error("pixel count register out of step with width and height");
	a_alpha_write: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == tga_rle_pkg::REG_HAS_ALPHA) |=> alpha_q == $past(cfg_data[0]))
		else $error("alpha flag not taken from write data");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_we |=> $stable(total_q) && $stable(alpha_q))
		else $error("configuration changed without a write");
`endif

endmodule

/* rtl/core/tga_rle_core.sv */
// packet decode state and per-byte result logic
// depends on tga_rle_pkg
module tga_rle_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   advance,
	input  tga_rle_pkg::in_item_t  item,
	input  tga_rle_pkg::cfg_t      cfg,
	output logic                   emit,
	output tga_rle_pkg::out_item_t result
);

	logic [tga_rle_pkg::COUNT_W-1:0] pixels_done_q;
	logic [7:0]                      raw_left_q;
	logic [7:0]                      repeat_count_q;
	logic                            in_repeat_q;
	logic                            expect_header_q;
	logic [1:0]                      byte_index_q;
	logic [23:0]                     color_q;
	logic                            finished_q;

	// state as seen by this byte, after a first-byte clear
	logic [tga_rle_pkg::COUNT_W-1:0] eff_pixels_done;
	logic [7:0]                      eff_raw_left;
	logic [7:0]                      eff_repeat_count;
	logic                            eff_in_repeat;
	logic                            eff_expect_header;
	logic [1:0]                      eff_byte_index;
	logic [23:0]                     eff_color;
	logic                            eff_finished;

	logic [tga_rle_pkg::COUNT_W-1:0] pixels_done_d;
	logic [7:0]                      raw_left_d;
	logic [7:0]                      repeat_count_d;
	logic                            in_repeat_d;
	logic                            expect_header_d;
	logic [1:0]                      byte_index_d;
	logic [23:0]                     color_d;
	logic                            finished_d;

	logic [7:0]                      b;
	logic [1:0]                      last_index;
	logic [7:0]                      run_n;
	logic [tga_rle_pkg::COUNT_W:0]   next_count;
	logic                            count_hit;
	logic                            header_next;

	assign b = item.data_byte;

	always_comb begin
		if (item.first) begin
			eff_pixels_done   = '0;
			eff_raw_left      = '0;
			eff_repeat_count  = '0;
			eff_in_repeat     = 1'b0;
			eff_expect_header = 1'b1;
			eff_byte_index    = '0;
			eff_color         = '0;
			eff_finished      = 1'b0;
		end else begin
			eff_pixels_done   = pixels_done_q;
			eff_raw_left      = raw_left_q;
			eff_repeat_count  = repeat_count_q;
			eff_in_repeat     = in_repeat_q;
			eff_expect_header = expect_header_q;
			eff_byte_index    = byte_index_q;
			eff_color         = color_q;
			eff_finished      = finished_q;
		end
	end

	assign last_index = cfg.has_alpha ? tga_rle_pkg::BYTE_ALPHA : tga_rle_pkg::BYTE_RED;
	assign run_n      = eff_in_repeat ? eff_repeat_count : 8'd1;
	assign next_count = {1'b0, eff_pixels_done} + (tga_rle_pkg::COUNT_W + 1)'(run_n);
	assign count_hit  = next_count == {1'b0, cfg.total};

	always_comb begin
		pixels_done_d   = eff_pixels_done;
		raw_left_d      = eff_raw_left;
		repeat_count_d  = eff_repeat_count;
		in_repeat_d     = eff_in_repeat;
		expect_header_d = eff_expect_header;
		byte_index_d    = eff_byte_index;
		color_d         = eff_color;
		finished_d      = eff_finished;
		header_next     = 1'b0;
		emit            = 1'b0;
		result          = '0;

		if (eff_finished) begin
			// bytes past the end of the image are dropped
		end else if (eff_expect_header) begin
			if (!b[7]) begin
				raw_left_d  = b + tga_rle_pkg::RAW_BIAS;
				in_repeat_d = 1'b0;
			end else begin
				repeat_count_d = b - tga_rle_pkg::REPEAT_BIAS;
				in_repeat_d    = 1'b1;
			end
			expect_header_d = 1'b0;
			byte_index_d    = '0;
		end else if (eff_byte_index < last_index) begin
			case (eff_byte_index)
				tga_rle_pkg::BYTE_BLUE:  color_d[7:0]   = b;
				tga_rle_pkg::BYTE_GREEN: color_d[15:8]  = b;
				tga_rle_pkg::BYTE_RED:   color_d[23:16] = b;
				default: begin
				end
			endcase
			byte_index_d = eff_byte_index + 2'd1;
		end else begin
			// last byte of a pixel
			if (!cfg.has_alpha && eff_byte_index == tga_rle_pkg::BYTE_RED)
				color_d[23:16] = b;
			byte_index_d = '0;
			emit         = 1'b1;
			if (next_count > {1'b0, cfg.total}) begin
				result.status = tga_rle_pkg::STATUS_OVERFLOW;
				finished_d    = 1'b1;
			end else begin
				pixels_done_d = next_count[tga_rle_pkg::COUNT_W-1:0];
				if (eff_in_repeat) begin
					header_next = 1'b1;
				end else begin
					if (eff_raw_left != 8'd0)
						raw_left_d = eff_raw_left - 8'd1;
					header_next = eff_raw_left <= 8'd1;
				end
				expect_header_d   = header_next;
				finished_d        = count_hit && header_next;
				result.red        = color_d[23:16];
				result.green      = color_d[15:8];
				result.blue       = color_d[7:0];
				result.alpha      = cfg.has_alpha ? b : 8'd0;
				result.run_length = run_n;
				result.image_done = count_hit;
				result.status     = tga_rle_pkg::STATUS_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixels_done_q   <= '0;
			raw_left_q      <= '0;
			repeat_count_q  <= '0;
			in_repeat_q     <= 1'b0;
			expect_header_q <= 1'b1;
			byte_index_q    <= '0;
			color_q         <= '0;
			finished_q      <= 1'b0;
		end else if (advance) begin
			pixels_done_q   <= pixels_done_d;
			raw_left_q      <= raw_left_d;
			repeat_count_q  <= repeat_count_d;
			in_repeat_q     <= in_repeat_d;
			expect_header_q <= expect_header_d;
			byte_index_q    <= byte_index_d;
			color_q         <= color_d;
			finished_q      <= finished_d;
		end
	end

`ifndef SYNTHESIS
	a_overflow_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && result.status) |=> finished_q)
		else $error("overflow did not stop the decoder");
	a_finished_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(finished_q && !item.first) |-> !emit)
		else $error("item emitted after the end of the image");
	a_header_silent: assert property (@(posedge clk) disable iff (!arst_n)
		eff_expect_header |-> !emit)
		else $error("packet header produced a pixel");
`endif

endmodule

/* verif/tb_tga_rle_pixel_decoder.sv */
// testbench for tga_rle_pixel_decoder: drives rle packet bytes, predicts the rgb(a) runs
// depends on tga_rle_pkg and the tga_rle_pixel_decoder rtl; stands alone otherwise
`timescale 1ns / 100ps

module tb_tga_rle_pixel_decoder;
	import tga_rle_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned PHASE_BYTES = 230;
	localparam int unsigned SETTLE      = 6;

	// keeps the decoder state and the pixels still owed by the block
	class pixel_scoreboard;
		logic [15:0] width;
		logic [15:0] height;
		logic        has_alpha;
		logic [31:0] pixels_done;
		logic [7:0]  raw_left;
		logic [7:0]  repeat_count;
		logic        in_repeat;
		logic        want_header;
		logic        finished;
		logic [1:0]  byte_pos;
		logic [23:0] color;
		out_item_t   pixel_q[$];
		int unsigned errors;
		int unsigned checked;
		int unsigned overflows;
		int unsigned image_ends;

		function new();
			width = 16'd1;
			height = 16'd1;
			has_alpha = 1'b0;
			restart();
		endfunction

		function void restart();
			pixels_done = '0;
			raw_left = '0;
			repeat_count = '0;
			in_repeat = 1'b0;
			want_header = 1'b1;
			finished = 1'b0;
			byte_pos = BYTE_BLUE;
			color = '0;
		endfunction

		function void set_reg(reg_index_t idx, logic [15:0] value);
			case (idx)
				REG_IMAGE_WIDTH:  width = value;
				REG_IMAGE_HEIGHT: height = value;
				REG_HAS_ALPHA:    has_alpha = value[0];
				default: ;
			endcase
		endfunction

		function int pending();
			return pixel_q.size();
		endfunction

		function void flag(string what);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", what);
		endfunction

		function void note_byte(in_item_t it);
			logic [1:0]  last_pos;
			logic [7:0]  n;
			logic [31:0] limit;
			logic [32:0] sum;
			out_item_t   px;
			last_pos = has_alpha ? BYTE_ALPHA : BYTE_RED;
			if (it.first)
				restart();
			if (finished)
				return;
			if (want_header) begin
				if (it.data_byte < 8'd128) begin
					raw_left = it.data_byte + RAW_BIAS;
					in_repeat = 1'b0;
				end else begin
					repeat_count = it.data_byte - REPEAT_BIAS;
					in_repeat = 1'b1;
				end
				want_header = 1'b0;
				byte_pos = BYTE_BLUE;
				return;
			end
			if (byte_pos < last_pos) begin
				color[byte_pos*8 +: 8] = it.data_byte;
				byte_pos = byte_pos + 2'd1;
				return;
			end
			// last byte of the pixel; after an alpha switch it may land past red
			px = '0;
			if (has_alpha)
				px.alpha = it.data_byte;
			else if (byte_pos == BYTE_RED)
				color[23:16] = it.data_byte;
			byte_pos = BYTE_BLUE;
			n = in_repeat ? repeat_count : 8'd1;
			limit = {16'd0, width} * {16'd0, height};
			sum = {1'b0, pixels_done} + {25'd0, n};
			if (sum > {1'b0, limit}) begin
				px = '0;
				px.status = STATUS_OVERFLOW;
				finished = 1'b1;
				pixel_q = {pixel_q, px};
				return;
			end
			pixels_done = sum[31:0];
			if (in_repeat)
				want_header = 1'b1;
			else begin
				if (raw_left != 0)
					raw_left--;
				if (raw_left == 0)
					want_header = 1'b1;
			end
			px.red = color[23:16];
			px.green = color[15:8];
			px.blue = color[7:0];
			px.run_length = n;
			px.image_done = (sum == {1'b0, limit});
			px.status = STATUS_OK;
			if (px.image_done && want_header)
				finished = 1'b1;
			pixel_q = {pixel_q, px};
		endfunction

		function void check_pixel(out_item_t got);
			out_item_t want;
			if (pixel_q.size() == 0) begin
				flag($sformatf("pixel %02h%02h%02h%02h run %0d done %0b status %0b with none due",
					got.red, got.green, got.blue, got.alpha, got.run_length,
					got.image_done, got.status));
				return;
			end
			want = pixel_q.pop_front();
			checked++;
			if (want.status == STATUS_OVERFLOW)
				overflows++;
			if (want.image_done)
				image_ends++;
			if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
					got.alpha !== want.alpha || got.run_length !== want.run_length ||
					got.image_done !== want.image_done || got.status !== want.status)
				flag($sformatf({"expected rgba %02h%02h%02h%02h run %0d done %0b status %0b, ",
					"got rgba %02h%02h%02h%02h run %0d done %0b status %0b"},
					want.red, want.green, want.blue, want.alpha, want.run_length,
					want.image_done, want.status, got.red, got.green, got.blue, got.alpha,
					got.run_length, got.image_done, got.status));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   pkt_valid = 1'b0;
	logic                   pkt_stall;
	in_item_t               pkt = '0;
	logic                   pix_valid;
	logic                   pix_stall = 1'b0;
	out_item_t              pix;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	pixel_scoreboard sb = new();

	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_done = 0;
	int unsigned hold_left = 0;
	int unsigned byte_count = 0;
	int unsigned image_count = 0;
	logic [15:0] img_w = 16'd1;
	logic [15:0] img_h = 16'd1;
	logic        img_alpha = 1'b0;

	tga_rle_pixel_decoder uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_stall (pkt_stall),
		.pkt       (pkt),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// receiver: random stalls, plus a long hold whenever the stimulus asks for one
	always @(posedge clk) begin
		if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			pix_stall <= 1'b1;
		end else if (holds_done != holds_asked) begin
			holds_done <= holds_done + 1;
			hold_left <= LONG_HOLD - 1;
			pix_stall <= 1'b1;
		end else
			pix_stall <= ($urandom_range(0, 99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall)
			sb.check_pixel(pix);
	end

	task automatic send_byte(input logic [7:0] value, input logic lead);
		in_item_t item;
		item.data_byte = value;
		item.first = lead;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			pkt_valid <= 1'b0;
			@(posedge clk);
		end
		pkt_valid <= 1'b1;
		pkt <= item;
		do
			@(posedge clk);
		while (pkt_stall);
		sb.note_byte(item);
		byte_count++;
	endtask

	// bytes go out as b, g, r and then a when the image carries alpha
	task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
			input logic [7:0] r, input logic [7:0] a);
		send_byte(b, 1'b0);
		send_byte(g, 1'b0);
		send_byte(r, 1'b0);
		if (img_alpha)
			send_byte(a, 1'b0);
	endtask

	task automatic send_random_pixel();
		send_pixel(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
	endtask

	task automatic drain();
		pkt_valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		sb.set_reg(idx, value);
	endtask

	task automatic configure(input logic [15:0] w, input logic [15:0] h, input logic a);
		drain();
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		write_reg(REG_HAS_ALPHA, {15'd0, a});
		cfg_we <= 1'b0;
		img_w = w;
		img_h = h;
		img_alpha = a;
	endtask

	task automatic pick_config();
		logic [15:0] w;
		logic [15:0] h;
		case ($urandom_range(0, 11))
			0: begin
				w = 16'hFFFF;
				h = 16'($urandom_range(1, 65535));
			end
			1: begin
				w = 16'($urandom_range(1, 65535));
				h = 16'hFFFF;
			end
			2: begin
				w = 16'($urandom_range(0, 3));
				h = (w == 0) ? 16'($urandom_range(0, 65535)) : 16'd0;
			end
			default: begin
				w = 16'($urandom_range(1, 6));
				h = 16'($urandom_range(1, 6));
			end
		endcase
		configure(w, h, 1'($urandom_range(0, 1)));
	endtask

	// mostly well-formed packets sized to the image, a few running past its end
	task automatic send_image();
		longint unsigned left;
		int unsigned     run;
		int unsigned     cap;
		int unsigned     packets;
		logic            lead;
		left = longint'(img_w) * longint'(img_h);
		packets = $urandom_range(1, 12);
		lead = 1'b1;
		image_count++;
		for (int p = 0; p < packets && left != 0; p++) begin
			cap = (left > 128) ? 128 : int'(left);
			if ($urandom_range(0, 9) == 0)
				cap = 128;
			if ($urandom_range(0, 1)) begin
				run = $urandom_range(1, cap);
				send_byte(8'(run + 127), lead);
				send_random_pixel();
			end else begin
				run = $urandom_range(1, (cap > 6) ? 6 : cap);
				send_byte(8'(run - 1), lead);
				repeat (run) send_random_pixel();
			end
			lead = 1'b0;
			left = (left > run) ? left - run : 0;
		end
		if ($urandom_range(0, 2) == 0)
			repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
	endtask

	task automatic send_noise();
		image_count++;
		repeat ($urandom_range(4, 20))
			send_byte(8'($urandom), $urandom_range(0, 7) == 0);
	endtask

	task automatic random_phase(input int unsigned snd, input int unsigned rcv,
			input logic squeeze);
		int unsigned start;
		send_idle_pct = snd;
		recv_idle_pct = rcv;
		start = byte_count;
		while (byte_count - start < PHASE_BYTES) begin
			pick_config();
			if (squeeze) begin
				// receiver holds off while the bytes keep coming
				configure(16'd64, 16'd64, 1'b0);
				holds_asked <= holds_asked + 1;
				squeeze = 1'b0;
				send_byte(8'h3F, 1'b1);
				repeat (64) send_random_pixel();
			end else if ($urandom_range(0, 11) == 0)
				send_noise();
			else
				send_image();
		end
	endtask

	initial begin
		send_idle_pct = 21;
		recv_idle_pct = 76;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset size of one pixel, then a byte past the end
		send_byte(8'h00, 1'b1);
		send_pixel(8'h00, 8'hFF, 8'h80, 8'h00);
		send_byte(8'h55, 1'b0);
		// largest image, longest repeat run and longest raw packet
		configure(16'hFFFF, 16'hFFFF, 1'b1);
		send_byte(8'hFF, 1'b1);
		send_pixel(8'hFF, 8'h00, 8'hAA, 8'hFF);
		send_byte(8'h7F, 1'b0);
		send_pixel(8'h01, 8'h02, 8'h03, 8'h04);
		// zero size overflows on the first pixel
		configure(16'd0, 16'd5, 1'b0);
		send_byte(8'h00, 1'b1);
		send_pixel(8'h11, 8'h22, 8'h33, 8'h00);
		// repeat run longer than the image
		configure(16'd4, 16'd1, 1'b0);
		send_byte(8'h84, 1'b1);
		send_pixel(8'h44, 8'h55, 8'h66, 8'h00);
		// count reached inside a raw packet, next raw pixel overflows
		configure(16'd1, 16'd2, 1'b0);
		send_byte(8'h02, 1'b1);
		repeat (3) send_random_pixel();
		// alpha flag switched in the middle of a pixel, both ways
		configure(16'd16, 16'd16, 1'b1);
		send_byte(8'h01, 1'b1);
		send_byte(8'h12, 1'b0);
		send_byte(8'h34, 1'b0);
		send_byte(8'h56, 1'b0);
		configure(16'd16, 16'd16, 1'b0);
		send_byte(8'h99, 1'b0);
		send_byte(8'hAB, 1'b0);
		send_byte(8'hCD, 1'b0);
		configure(16'd16, 16'd16, 1'b1);
		send_byte(8'hEF, 1'b0);
		send_byte(8'h77, 1'b0);

		random_phase(21, 76, 1'b0);
		random_phase(76, 21, 1'b0);
		random_phase(0, 0, 1'b1);

		drain();
		if (sb.pending() != 0)
			sb.flag($sformatf("%0d pixels never arrived", sb.pending()));
		$display("sent %0d bytes over %0d images and streams, %0d mismatches",
			byte_count, image_count, sb.errors);
		$display("checked %0d results: %0d overflows, %0d image ends",
			sb.checked, sb.overflows, sb.image_ends);
		if (sb.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
